// ----- sv/smro_pkg.sv -----
// smro_pkg: widths, codes and shared types of the strided mixed-radix odometer.
// No dependencies; every other file of the block imports it.
package smro_pkg;

    // Sizing of the wheel store and the word table.
    localparam int MAX_WHEELS        = 24;
    localparam int MAX_WHEEL_ENTRIES = 2048;
    localparam int WHL_AW            = $clog2(MAX_WHEELS);
    localparam int ENT_AW            = $clog2(MAX_WHEEL_ENTRIES);
    localparam int WT_DEPTH          = MAX_WHEELS * MAX_WHEEL_ENTRIES;
    localparam int WT_AW             = WHL_AW + ENT_AW;

    // Field widths.
    localparam int ACT_W    = 2;
    localparam int WHEEL_W  = 5;
    localparam int ENTRY_W  = 11;
    localparam int WORD_W   = 11;
    localparam int RAD_W    = 12;
    localparam int SLOT_W   = 5;
    localparam int DIG_W    = 11;
    localparam int CNT_W    = 5;
    localparam int STRIDE_W = 16;
    localparam int OFS_W    = 16;

    // Running carry or quotient, and the remaining-result counter.
    localparam int ACC_W    = 17;
    localparam int STEP_W   = $clog2(ACC_W + 1);
    localparam int ECNT_W   = $clog2(MAX_WHEELS + 1);

    // Configuration port.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_WHEEL_COUNT  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_STRIDE       = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_START_OFFSET = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SIZE  = 2'd1,
        ACT_START = 2'd2,
        ACT_ADV   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_C_RD,
        S_C_WT,
        S_C_DIV,
        S_E_RD,
        S_E_WT,
        S_E_OUT,
        S_NOUPD
    } t_state;

    // Write request to the wheel store: digit and size/slot are written separately.
    typedef struct packed {
        logic              dig_we;
        logic              cfg_we;
        logic [WHL_AW-1:0] addr;
        logic [DIG_W-1:0]  digit;
        logic [RAD_W-1:0]  radix;
        logic [SLOT_W-1:0] slot;
    } t_whl_wr;

    typedef struct packed {
        logic [DIG_W-1:0]  digit;
        logic [RAD_W-1:0]  radix;
        logic [SLOT_W-1:0] slot;
    } t_whl_rd;

    typedef struct packed {
        logic              we;
        logic [WT_AW-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_wt_wr;

endpackage

// ----- sv/smro_div.sv -----
// smro_div: restoring divider, one quotient bit per clock, giving quotient and remainder.
// Depends on smro_pkg.
module smro_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smro_pkg::ACC_W-1:0]    i_dividend,
    input  logic [smro_pkg::RAD_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [smro_pkg::ACC_W-1:0]    o_quotient,
    output logic [smro_pkg::RAD_W-1:0]    o_remainder
);
    import smro_pkg::*;

    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_quo, n_quo;
    logic [RAD_W-1:0]  r_rem, n_rem;
    logic [RAD_W-1:0]  r_dvs, n_dvs;
    logic              r_done, n_done;
    logic [RAD_W:0]    w_trial;
    logic [RAD_W:0]    w_diff;
    logic              w_ge;

    // The partial remainder stays below the divisor, so one more bit fits in RAD_W+1.
    always_comb begin
        w_trial = {r_rem, r_quo[ACC_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
            n_cnt = STEP_W'(ACC_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? w_diff[RAD_W-1:0] : w_trial[RAD_W-1:0];
            n_quo  = {r_quo[ACC_W-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- sv/smro_wheel_mem.sv -----
// smro_wheel_mem: per-wheel store of digit, size and slot with a registered read port.
// Depends on smro_pkg; digits carry valid bits so that reset reads them as zero.
module smro_wheel_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smro_pkg::t_whl_wr             i_wr,
    input  logic [smro_pkg::WHL_AW-1:0]   i_rd_addr,
    output smro_pkg::t_whl_rd             o_rd
);
    import smro_pkg::*;

    logic [DIG_W-1:0]      r_dig_mem  [MAX_WHEELS];
    logic [RAD_W-1:0]      r_rad_mem  [MAX_WHEELS];
    logic [SLOT_W-1:0]     r_slot_mem [MAX_WHEELS];
    logic [MAX_WHEELS-1:0] r_dig_vld;
    logic [DIG_W-1:0]      r_rd_dig;
    logic [RAD_W-1:0]      r_rd_rad;
    logic [SLOT_W-1:0]     r_rd_slot;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.dig_we) begin
            r_dig_mem[i_wr.addr] <= i_wr.digit;
        end
        if (i_wr.cfg_we) begin
            r_rad_mem[i_wr.addr]  <= i_wr.radix;
            r_slot_mem[i_wr.addr] <= i_wr.slot;
        end
        r_rd_dig  <= r_dig_mem[i_rd_addr];
        r_rd_rad  <= r_rad_mem[i_rd_addr];
        r_rd_slot <= r_slot_mem[i_rd_addr];
        r_rd_vld  <= r_dig_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_vld <= '0;
        end else if (i_wr.dig_we) begin
            r_dig_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd.digit = r_rd_vld ? r_rd_dig : '0;
    assign o_rd.radix = r_rd_rad;
    assign o_rd.slot  = r_rd_slot;

endmodule

// ----- sv/smro_word_mem.sv -----
// smro_word_mem: word id table of all wheels, one write and one registered read port.
// Depends on smro_pkg.
module smro_word_mem (
    input  logic                          i_clk,
    input  smro_pkg::t_wt_wr              i_wr,
    input  logic [smro_pkg::WT_AW-1:0]    i_rd_addr,
    output logic [smro_pkg::WORD_W-1:0]   o_rd_data
);
    import smro_pkg::*;

    logic [WORD_W-1:0] r_mem [WT_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/strided_mixed_radix_odometer_top.sv -----
// strided_mixed_radix_odometer_top: sequencer of the strided mixed-radix odometer.
// Depends on smro_pkg, smro_wheel_mem, smro_word_mem and smro_div.
//
// Channel  | Handshake                       | Word carried
// ---------+---------------------------------+------------------------------------------
// command  | start in, busy out              | action, wheel, entry, word_value,
//          | (taken when start & !busy)      | wheel_size, target_position
// result   | o_strobe out, one cycle, no     | position, word_id, no_update,
//          | back-pressure                   | exhausted, last
// config   | i_cfg_valid in, o_cfg_ready out | register index, 16-bit data
//
// A load word leaves busy low. A start over n wheels touches every wheel; an advance
// touches only the wheels up to where its carry dies out. Each touched wheel costs a
// wheel store read, a division in the bit-serial divider and, for output, a wheel read
// followed by a word table read.
// Reset is synchronous and active low; it clears the sequencer, the exhausted flag, the
// digit valid bits and the configuration registers, except the stride, which resets to
// one. The word table and the wheel sizes and slots are not cleared. Results cannot be
// stalled: each is shown for exactly one cycle.
module strided_mixed_radix_odometer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [smro_pkg::ACT_W-1:0]    i_action,
    input  logic [smro_pkg::WHEEL_W-1:0]  i_wheel,
    input  logic [smro_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [smro_pkg::WORD_W-1:0]   i_word_value,
    input  logic [smro_pkg::RAD_W-1:0]    i_wheel_size,
    input  logic [smro_pkg::SLOT_W-1:0]   i_target_position,
    // Configuration channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [smro_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [smro_pkg::CFG_DW-1:0]   i_cfg_data,
    // Result channel.
    output logic                          o_strobe,
    output logic [smro_pkg::SLOT_W-1:0]   o_position,
    output logic [smro_pkg::WORD_W-1:0]   o_word_id,
    output logic                          o_no_update,
    output logic                          o_exhausted,
    output logic                          o_last
);
    import smro_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0]    r_wheel_count;
    logic [STRIDE_W-1:0] r_stride;
    logic [OFS_W-1:0]    r_start_offset;

    // Sequencer state.
    t_state              r_state, n_state;
    logic                r_adv, n_adv;
    logic [WHL_AW-1:0]   r_idx, n_idx;
    logic [WHL_AW-1:0]   r_eidx, n_eidx;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ECNT_W-1:0]   r_ecnt, n_ecnt;
    logic                r_done, n_done;
    logic [SLOT_W-1:0]   r_pos, n_pos;

    // Result registers.
    logic                r_o_strobe, n_o_strobe;
    logic [SLOT_W-1:0]   r_o_position, n_o_position;
    logic [WORD_W-1:0]   r_o_word_id, n_o_word_id;
    logic                r_o_no_update, n_o_no_update;
    logic                r_o_exhausted, n_o_exhausted;
    logic                r_o_last, n_o_last;

    // Memory and divider connections.
    t_whl_wr             w_whl_wr;
    t_whl_rd             w_whl_rd;
    logic [WHL_AW-1:0]   w_whl_rd_addr;
    t_wt_wr              w_wt_wr;
    logic [WT_AW-1:0]    w_wt_rd_addr;
    logic [WORD_W-1:0]   w_wt_rd_data;
    logic                w_div_start;
    logic [ACC_W-1:0]    w_dividend;
    logic                w_div_done;
    logic [ACC_W-1:0]    w_div_quo;
    logic [RAD_W-1:0]    w_div_rem;

    // Derived values.
    logic [CNT_W-1:0]    w_nwh;
    logic [WHL_AW-1:0]   w_top;
    logic [RAD_W-1:0]    w_size;
    logic                w_wheel_ok;

    smro_wheel_mem u_wheel_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_whl_wr),
        .i_rd_addr (w_whl_rd_addr),
        .o_rd      (w_whl_rd)
    );

    smro_word_mem u_word_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wt_wr),
        .i_rd_addr (w_wt_rd_addr),
        .o_rd_data (w_wt_rd_data)
    );

    smro_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_whl_rd.radix),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // The wheel count saturates at the number of wheels the store holds; the least
    // significant wheel is the last one in use.
    assign w_nwh      = (r_wheel_count > CNT_W'(MAX_WHEELS)) ? CNT_W'(MAX_WHEELS)
                                                             : r_wheel_count;
    assign w_top      = WHL_AW'(w_nwh - 1'b1);
    assign w_wheel_ok = ({1'b0, i_wheel} < (WHEEL_W + 1)'(MAX_WHEELS));

    // A size of zero is kept as one and an oversized wheel is cut to the table depth.
    assign w_size = (i_wheel_size == '0) ? RAD_W'(1) :
                    (i_wheel_size > RAD_W'(MAX_WHEEL_ENTRIES)) ? RAD_W'(MAX_WHEEL_ENTRIES) :
                    i_wheel_size;

    // A start divides the running quotient; an advance divides digit plus carry.
    assign w_dividend = r_adv ? (ACC_W'(w_whl_rd.digit) + r_acc) : r_acc;

    always_comb begin
        n_state       = r_state;
        n_adv         = r_adv;
        n_idx         = r_idx;
        n_eidx        = r_eidx;
        n_acc         = r_acc;
        n_ecnt        = r_ecnt;
        n_done        = r_done;
        n_pos         = r_pos;
        n_o_strobe    = 1'b0;
        n_o_position  = r_o_position;
        n_o_word_id   = r_o_word_id;
        n_o_no_update = r_o_no_update;
        n_o_exhausted = r_o_exhausted;
        n_o_last      = r_o_last;
        w_whl_wr      = '0;
        w_wt_wr       = '0;
        w_div_start   = 1'b0;
        w_whl_rd_addr = r_idx;
        w_wt_rd_addr  = {r_eidx, w_whl_rd.digit};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            if (w_wheel_ok) begin
                                w_wt_wr.we   = 1'b1;
                                w_wt_wr.addr = {i_wheel[WHL_AW-1:0], i_entry};
                                w_wt_wr.data = i_word_value;
                            end
                        end
                        ACT_SIZE: begin
                            if (w_wheel_ok) begin
                                w_whl_wr.cfg_we = 1'b1;
                                w_whl_wr.addr   = i_wheel[WHL_AW-1:0];
                                w_whl_wr.radix  = w_size;
                                w_whl_wr.slot   = i_target_position;
                            end
                        end
                        ACT_START: begin
                            n_adv = 1'b0;
                            if (w_nwh == '0) begin
                                // With no wheels the whole offset is left over.
                                n_done  = (r_start_offset != '0);
                                n_state = S_NOUPD;
                            end else begin
                                n_idx   = w_top;
                                n_acc   = ACC_W'(r_start_offset);
                                n_ecnt  = '0;
                                n_state = S_C_RD;
                            end
                        end
                        ACT_ADV: begin
                            n_adv = 1'b1;
                            if (r_done || (w_nwh == '0) || (r_stride == '0)) begin
                                n_state = S_NOUPD;
                            end else begin
                                n_idx   = w_top;
                                n_acc   = ACC_W'(r_stride);
                                n_ecnt  = '0;
                                n_state = S_C_RD;
                            end
                        end
                    endcase
                end
            end
            S_C_RD: begin
                n_state = S_C_WT;
            end
            S_C_WT: begin
                // Wheel data is now out of the store: launch the division.
                w_div_start = 1'b1;
                n_state     = S_C_DIV;
            end
            S_C_DIV: begin
                if (w_div_done) begin
                    w_whl_wr.dig_we = 1'b1;
                    w_whl_wr.addr   = r_idx;
                    w_whl_wr.digit  = w_div_rem[DIG_W-1:0];
                    n_acc           = w_div_quo;
                    n_ecnt          = r_ecnt + 1'b1;
                    // A start runs through every wheel; an advance stops once the
                    // carry dies out. Whatever is left past the top wheel exhausts it.
                    if ((r_idx == '0) || (r_adv && (w_div_quo == '0))) begin
                        n_done  = (w_div_quo != '0);
                        n_eidx  = r_adv ? w_top : '0;
                        n_state = S_E_RD;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_C_RD;
                    end
                end
            end
            S_E_RD: begin
                w_whl_rd_addr = r_eidx;
                n_state       = S_E_WT;
            end
            S_E_WT: begin
                // Digit selects the entry of this wheel's table.
                w_wt_rd_addr = {r_eidx, w_whl_rd.digit};
                n_pos        = w_whl_rd.slot;
                n_state      = S_E_OUT;
            end
            S_E_OUT: begin
                n_o_strobe    = 1'b1;
                n_o_position  = r_pos;
                n_o_word_id   = w_wt_rd_data;
                n_o_no_update = 1'b0;
                n_o_exhausted = r_done;
                n_o_last      = (r_ecnt == ECNT_W'(1));
                n_ecnt        = r_ecnt - 1'b1;
                n_eidx        = r_adv ? (r_eidx - 1'b1) : (r_eidx + 1'b1);
                n_state       = (r_ecnt == ECNT_W'(1)) ? S_IDLE : S_E_RD;
            end
            S_NOUPD: begin
                n_o_strobe    = 1'b1;
                n_o_position  = '0;
                n_o_word_id   = '0;
                n_o_no_update = 1'b1;
                n_o_exhausted = r_done;
                n_o_last      = 1'b1;
                n_state       = S_IDLE;
            end
        endcase
    end

    // Configuration registers are written only while the sequencer is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_count  <= '0;
            r_stride       <= STRIDE_W'(1);
            r_start_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WHEEL_COUNT:  r_wheel_count  <= i_cfg_data[CNT_W-1:0];
                CFG_STRIDE:       r_stride       <= i_cfg_data[STRIDE_W-1:0];
                CFG_START_OFFSET: r_start_offset <= i_cfg_data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adv         <= n_adv;
        r_idx         <= n_idx;
        r_eidx        <= n_eidx;
        r_acc         <= n_acc;
        r_ecnt        <= n_ecnt;
        r_pos         <= n_pos;
        r_o_position  <= n_o_position;
        r_o_word_id   <= n_o_word_id;
        r_o_no_update <= n_o_no_update;
        r_o_exhausted <= n_o_exhausted;
        r_o_last      <= n_o_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_strobe    = r_o_strobe;
    assign o_position  = r_o_position;
    assign o_word_id   = r_o_word_id;
    assign o_no_update = r_o_no_update;
    assign o_exhausted = r_o_exhausted;
    assign o_last      = r_o_last;

`ifndef SYNTH
    // The sequencer returns to idle only by handing out the final result of a word.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_strobe && o_last))
        else $error("sequencer went idle without a final result");

    // A no-update result is always the only one and carries an empty payload.
    a_noupd_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_no_update) |-> (o_last && (o_position == '0) && (o_word_id == '0)))
        else $error("malformed no-update result");

    // Results that are not final leave the sequencer working on the same word.
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final result with the sequencer idle");

    // Every result of a word reports the exhausted flag as it stands after that word.
    a_exh_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_no_update) |-> (o_exhausted == r_done))
        else $error("exhausted flag differs from counter state");
`endif

endmodule
